### design/yoyo_pkg.sv
// Shared constants and controller/datapath interface types for the Yo-Yo election node.
package yoyo_pkg;

    localparam int NUM_LINKS = 8;
    localparam int LINK_W    = 3;
    localparam int RANK_W    = 16;
    localparam int CNT_W     = 4;
    localparam int NUM_GRP   = 4;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SETUP = 3'd1;
    localparam logic [2:0] PH_YO    = 3'd2;
    localparam logic [2:0] PH_REPLY = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_RANK  = 3'd1;
    localparam logic [2:0] MODE_YO    = 3'd2;
    localparam logic [2:0] MODE_REPLY = 3'd3;
    localparam logic [2:0] MODE_PRUNE = 3'd4;

    localparam logic [2:0] K_RANK   = 3'd0;
    localparam logic [2:0] K_YO     = 3'd1;
    localparam logic [2:0] K_REPLY  = 3'd2;
    localparam logic [2:0] K_PRUNE  = 3'd3;
    localparam logic [2:0] K_LEADER = 3'd4;
    localparam logic [2:0] K_DROP   = 3'd5;

    localparam logic [1:0] CFG_OWN_RANK = 2'd0;
    localparam logic [1:0] CFG_NBR_CNT  = 2'd1;

    typedef struct packed {
        logic load;
        logic apply;
        logic close;
        logic round;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pending;
    } t_stat;

endpackage

### design/yoyo_ctrl.sv
// Sequencing state machine: load, apply, close, new round, emit.
module yoyo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  yoyo_pkg::t_stat i_stat,
    output yoyo_pkg::t_cmd  o_cmd
);
    import yoyo_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APPLY = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = accept;
        o_cmd.apply = (r_state == S_APPLY);
        o_cmd.close = (r_state == S_CLOSE);
        o_cmd.round = (r_state == S_ROUND);
        o_cmd.emit  = (r_state == S_EMIT);
        n_state     = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_APPLY;
            S_APPLY: n_state = S_CLOSE;
            S_CLOSE: n_state = S_ROUND;
            S_ROUND: n_state = S_EMIT;
            S_EMIT:  if (!i_stat.pending) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_APPLY) else $error("accept did not start apply");
    a_apply_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPLY |=> r_state == S_CLOSE) else $error("apply not followed by close");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_stat.pending) |=> r_state == S_IDLE)
        else $error("emit did not finish");

endmodule

### design/yoyo_dp.sv
// Election state, message update, phase close and result word sequencer.
module yoyo_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  yoyo_pkg::t_cmd               i_cmd,
    output yoyo_pkg::t_stat              o_stat,
    input  logic                         i_cfg_valid,
    input  logic [1:0]                   i_cfg_index,
    input  logic [yoyo_pkg::RANK_W-1:0]  i_cfg_data,
    input  logic [2:0]                   i_mode,
    input  logic [yoyo_pkg::LINK_W-1:0]  i_source,
    input  logic [yoyo_pkg::RANK_W-1:0]  i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [yoyo_pkg::LINK_W-1:0]  o_dest,
    output logic [2:0]                   o_msg_kind,
    output logic [yoyo_pkg::RANK_W-1:0]  o_value_res,
    output logic                         o_last
);
    import yoyo_pkg::*;

    logic [RANK_W-1:0]    r_own_rank;
    logic [CNT_W-1:0]     r_ncount;

    logic [2:0]           r_mode, n_mode;
    logic [LINK_W-1:0]    r_src, n_src;
    logic [RANK_W-1:0]    r_val, n_val;

    logic [2:0]           r_phase, n_phase;
    logic [NUM_LINKS-1:0] r_alive, n_alive;
    logic [NUM_LINKS-1:0] r_out, n_out;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [RANK_W-1:0]    r_vals [NUM_LINKS];
    logic [NUM_LINKS-1:0] r_seen, n_seen;
    logic [NUM_LINKS-1:0] r_dup, n_dup;
    logic [RANK_W-1:0]    r_min, n_min;
    logic                 r_allyes, n_allyes;
    logic [NUM_LINKS-1:0] r_turn, n_turn;
    logic [NUM_LINKS-1:0] r_replied, n_replied;
    logic                 r_close_yo, n_close_yo;
    logic                 r_close_rp, n_close_rp;
    logic                 r_need_round, n_need_round;

    logic [NUM_LINKS-1:0] r_gm [NUM_GRP];
    logic [NUM_LINKS-1:0] n_gm [NUM_GRP];
    logic [2:0]           r_gk [NUM_GRP];
    logic [2:0]           n_gk [NUM_GRP];
    logic [RANK_W-1:0]    r_gv [NUM_GRP];
    logic [RANK_W-1:0]    n_gv [NUM_GRP];

    logic                 r_ov, n_ov;
    logic [LINK_W-1:0]    r_odest, n_odest;
    logic [2:0]           r_okind, n_okind;
    logic [RANK_W-1:0]    r_oval, n_oval;
    logic                 r_olast, n_olast;

    logic [CNT_W-1:0]     n_use;
    logic [NUM_LINKS-1:0] n_mask, b, in_m, out_m, eqv, eqmin, seen2, dup2, rep2, alive2;
    logic [NUM_LINKS-1:0] pm, yes_m, no_m, rem_any;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 dup, ok, vwe, pending, pop, found, bfound;
    logic [1:0]           gsel;
    logic [LINK_W-1:0]    bsel;

    always_comb begin
        n_use   = (r_ncount > CNT_W'(NUM_LINKS)) ? CNT_W'(NUM_LINKS) : r_ncount;
        n_mask  = NUM_LINKS'((9'd1 << n_use) - 9'd1);
        b       = NUM_LINKS'(1) << r_src;
        in_m    = r_alive & ~r_out;
        out_m   = r_alive & r_out;
        cnt_inc = r_cnt + CNT_W'(1);
        for (int i = 0; i < NUM_LINKS; i++) begin
            eqv[i]   = (r_vals[i] == r_val);
            eqmin[i] = (r_vals[i] == r_min);
        end
        dup = |(r_seen & eqv);
    end

    // result sequencer: first nonempty group, lowest link first
    always_comb begin
        found = 1'b0;
        gsel  = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            if (!found && r_gm[g] != '0) begin
                found = 1'b1;
                gsel  = 2'(g);
            end
        end
        bfound = 1'b0;
        bsel   = '0;
        for (int i = 0; i < NUM_LINKS; i++) begin
            if (!bfound && r_gm[gsel][i]) begin
                bfound = 1'b1;
                bsel   = LINK_W'(i);
            end
        end
        pending = found;
        pop     = i_cmd.emit && pending && (!r_ov || !i_out_stall);
        rem_any = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            rem_any = rem_any | ((2'(g) == gsel) ? (r_gm[g] & ~(NUM_LINKS'(1) << bsel))
                                                  : r_gm[g]);
        end
    end

    assign o_stat.pending = pending;

    always_comb begin
        n_mode = r_mode; n_src = r_src; n_val = r_val;
        n_phase = r_phase; n_alive = r_alive; n_out = r_out; n_cnt = r_cnt;
        n_seen = r_seen; n_dup = r_dup; n_min = r_min; n_allyes = r_allyes;
        n_turn = r_turn; n_replied = r_replied;
        n_close_yo = r_close_yo; n_close_rp = r_close_rp; n_need_round = r_need_round;
        n_gm = r_gm; n_gk = r_gk; n_gv = r_gv;
        n_ov = r_ov; n_odest = r_odest; n_okind = r_okind; n_oval = r_oval; n_olast = r_olast;
        ok = 1'b0; vwe = 1'b0;
        seen2 = r_seen; dup2 = r_dup; rep2 = r_replied; alive2 = r_alive;
        pm = in_m & r_dup;
        yes_m = '0; no_m = '0;

        if (i_cmd.load) begin
            n_mode = i_mode;
            n_src  = i_source;
            n_val  = i_value;
        end

        if (i_cmd.apply) begin
            for (int g = 0; g < NUM_GRP; g++) n_gm[g] = '0;
            n_close_yo = 1'b0; n_close_rp = 1'b0; n_need_round = 1'b0;
            if (r_mode == MODE_START && r_phase == PH_IDLE) begin
                ok = 1'b1;
                n_alive = '0; n_out = '0; n_cnt = '0;
                n_gm[0] = n_mask; n_gk[0] = K_RANK; n_gv[0] = r_own_rank;
                n_phase = PH_SETUP;
                n_need_round = (n_use == '0);
            end else if (r_mode == MODE_RANK && r_phase == PH_SETUP
                         && {1'b0, r_src} < n_use && !(|(r_alive & b))) begin
                ok = 1'b1;
                n_alive = r_alive | b;
                if (!(r_val < r_own_rank)) n_out = r_out | b;
                n_cnt = cnt_inc;
                n_need_round = (cnt_inc >= n_use);
            end else if (r_mode == MODE_YO && r_phase == PH_YO
                         && |(in_m & ~(r_seen | r_dup) & b)) begin
                ok = 1'b1;
                if (dup) begin
                    dup2 = r_dup | b;
                end else begin
                    seen2 = r_seen | b;
                    vwe   = 1'b1;
                    if (r_val < r_min) n_min = r_val;
                end
                n_seen = seen2; n_dup = dup2;
                n_cnt = cnt_inc;
                n_close_yo = ((in_m & ~(seen2 | dup2)) == '0);
            end else if ((r_mode == MODE_REPLY || r_mode == MODE_PRUNE) && r_phase == PH_REPLY
                         && |(out_m & ~r_replied & b)) begin
                ok = 1'b1;
                rep2 = r_replied | b;
                if (r_mode == MODE_PRUNE) begin
                    alive2 = r_alive & ~b;
                end else if (!r_val[0]) begin
                    n_allyes = 1'b0;
                    n_turn   = r_turn | b;
                end
                n_replied = rep2; n_alive = alive2;
                n_cnt = cnt_inc;
                n_close_rp = ((alive2 & r_out & ~rep2) == '0);
            end
            if (!ok) begin
                n_gm[0] = b; n_gk[0] = K_DROP; n_gv[0] = r_val;
            end
        end

        if (i_cmd.close && (r_close_yo || r_close_rp)) begin
            if (r_close_yo && out_m != '0) begin
                n_gm[0] = out_m; n_gk[0] = K_YO; n_gv[0] = r_min;
                n_phase = PH_REPLY;
            end else if (r_close_yo && $countones(in_m) == 1) begin
                n_gm[0] = in_m; n_gk[0] = K_PRUNE; n_gv[0] = RANK_W'(1);
                n_alive = r_alive & ~in_m;
                n_phase = PH_DONE;
            end else begin
                yes_m = (r_close_yo || r_allyes) ? (in_m & ~r_dup & eqmin) : '0;
                no_m  = in_m & ~r_dup & ~yes_m;
                n_gm[0] = pm;    n_gk[0] = K_PRUNE; n_gv[0] = RANK_W'(1);
                n_gm[1] = yes_m; n_gk[1] = K_REPLY; n_gv[1] = RANK_W'(1);
                n_gm[2] = no_m;  n_gk[2] = K_REPLY; n_gv[2] = RANK_W'(0);
                n_alive = r_alive & ~pm;
                n_out   = (r_out | no_m) & ~(r_close_rp ? r_turn : '0);
                n_need_round = 1'b1;
            end
        end

        if (i_cmd.round && r_need_round) begin
            n_seen = '0; n_dup = '0; n_turn = '0; n_replied = '0;
            n_min = '1; n_allyes = 1'b1; n_cnt = '0;
            if (in_m != '0) begin
                n_phase = PH_YO;
            end else if (out_m == '0) begin
                n_gm[3] = NUM_LINKS'(1); n_gk[3] = K_LEADER; n_gv[3] = r_own_rank;
                n_phase = PH_DONE;
            end else begin
                n_gm[3] = out_m; n_gk[3] = K_YO; n_gv[3] = r_own_rank;
                n_phase = PH_REPLY;
            end
        end

        if (pop) begin
            n_gm[gsel] = r_gm[gsel] & ~(NUM_LINKS'(1) << bsel);
            n_ov    = 1'b1;
            n_odest = bsel;
            n_okind = r_gk[gsel];
            n_oval  = r_gv[gsel];
            n_olast = (rem_any == '0);
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_rank <= '0;
            r_ncount   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_RANK: r_own_rank <= i_cfg_data;
                CFG_NBR_CNT:  r_ncount   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode; r_src <= n_src; r_val <= n_val;
        r_gk <= n_gk; r_gv <= n_gv;
        r_odest <= n_odest; r_okind <= n_okind; r_oval <= n_oval; r_olast <= n_olast;
        if (vwe) r_vals[r_src] <= r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_alive <= '0; r_out <= '0; r_cnt <= '0;
            r_seen <= '0; r_dup <= '0; r_min <= '1; r_allyes <= 1'b1;
            r_turn <= '0; r_replied <= '0;
            r_close_yo <= 1'b0; r_close_rp <= 1'b0; r_need_round <= 1'b0;
            for (int g = 0; g < NUM_GRP; g++) r_gm[g] <= '0;
            r_ov <= 1'b0;
        end else begin
            r_phase <= n_phase; r_alive <= n_alive; r_out <= n_out; r_cnt <= n_cnt;
            r_seen <= n_seen; r_dup <= n_dup; r_min <= n_min; r_allyes <= n_allyes;
            r_turn <= n_turn; r_replied <= n_replied;
            r_close_yo <= n_close_yo; r_close_rp <= n_close_rp; r_need_round <= n_need_round;
            r_gm <= n_gm;
            r_ov <= n_ov;
        end
    end

    assign o_out_valid = r_ov;
    assign o_dest      = r_odest;
    assign o_msg_kind  = r_okind;
    assign o_value_res = r_oval;
    assign o_last      = r_olast;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |=> r_phase == PH_DONE) else $error("left done phase");
    a_seen_dup_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen & r_dup) == '0) else $error("link both seen and duplicate");
    a_pop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_ov) else $error("popped word not presented");

endmodule

### design/yoyo_election_node_top.sv
// One node of Yo-Yo leader election with duplicate pruning. After a message is accepted the
// input stalls through the update, phase close and new round steps and then the emit step,
// which lasts until the single result sequencer, presenting one word per cycle while the
// output is not stalled, has no result word left. The last result word may still wait at the
// output while the next message is accepted. Configuration (own rank at index 0, neighbor
// count at index 1) is always ready; the user must write it only between messages, and the
// block itself does not enforce this.
module yoyo_election_node_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_source,
    input  logic [15:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_dest,
    output logic [2:0]  o_msg_kind,
    output logic [15:0] o_value_res,
    output logic        o_last
);
    import yoyo_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    yoyo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    yoyo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_source    (i_source),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dest      (o_dest),
        .o_msg_kind  (o_msg_kind),
        .o_value_res (o_value_res),
        .o_last      (o_last)
    );

endmodule

### test/yoyo_election_node_top_test.sv
// Testbench for the Yo-Yo election node: drives messages and checks every send word.
`timescale 1ns / 1ps

module yoyo_election_node_top_test;
    import yoyo_pkg::*;

    typedef struct {
        logic [2:0]  dest;
        logic [2:0]  kind;
        logic [15:0] value;
        logic        last;
    } t_send_word;

    class t_election_scoreboard;
        logic [15:0] own_rank;
        logic [3:0]  nbr_cnt;
        logic [2:0]  phase;
        logic [7:0]  alive, outg, seen, dup, turn, replied;
        logic [3:0]  counted;
        logic [15:0] vals [8];
        logic [15:0] rmin;
        logic        all_yes;
        t_send_word  pending [$];
        t_send_word  batch [$];
        int          errors;

        function new();
            own_rank = 0;
            nbr_cnt = 0;
            phase = PH_IDLE;
            alive = 0;
            outg = 0;
            seen = 0;
            dup = 0;
            turn = 0;
            replied = 0;
            counted = 0;
            foreach (vals[i]) vals[i] = 0;
            rmin = 16'hFFFF;
            all_yes = 1;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == CFG_OWN_RANK) own_rank = data;
            else if (idx == CFG_NBR_CNT) nbr_cnt = data[3:0];
        endfunction

        function int links();
            return (nbr_cnt > 8) ? 8 : int'(nbr_cnt);
        endfunction

        function void emit(int d, logic [2:0] k, logic [15:0] v);
            t_send_word w;
            if (batch.size() >= 16) return;
            w.dest = d[2:0];
            w.kind = k;
            w.value = v;
            w.last = 0;
            batch = {batch, w};
        endfunction

        function void start_round();
            logic [7:0] inm, outm;
            inm = alive & ~outg;
            outm = alive & outg;
            seen = 0;
            dup = 0;
            turn = 0;
            replied = 0;
            rmin = 16'hFFFF;
            all_yes = 1;
            counted = 0;
            if (inm != 0) begin
                phase = PH_YO;
            end else if (outm == 0) begin
                emit(0, K_LEADER, own_rank);
                phase = PH_DONE;
            end else begin
                for (int i = 0; i < 8; i++)
                    if (outm[i]) emit(i, K_YO, own_rank);
                phase = PH_REPLY;
            end
        endfunction

        function void answer_incoming(logic final_yes);
            logic [7:0] inm, yes_set, no_set;
            inm = alive & ~outg;
            yes_set = 0;
            no_set = 0;
            for (int i = 0; i < 8; i++) begin
                if (!inm[i]) continue;
                if (dup[i]) begin
                    emit(i, K_PRUNE, 16'd1);
                    alive[i] = 0;
                end else if (final_yes && vals[i] == rmin) begin
                    yes_set[i] = 1;
                end else begin
                    no_set[i] = 1;
                end
            end
            for (int i = 0; i < 8; i++) if (yes_set[i]) emit(i, K_REPLY, 16'd1);
            for (int i = 0; i < 8; i++) if (no_set[i]) emit(i, K_REPLY, 16'd0);
            outg = outg | no_set;
        endfunction

        function void close_yo();
            logic [7:0] inm, outm;
            int cnt, only;
            inm = alive & ~outg;
            outm = alive & outg;
            cnt = 0;
            only = 0;
            for (int i = 0; i < 8; i++) if (outm[i]) emit(i, K_YO, rmin);
            if (outm != 0) begin
                phase = PH_REPLY;
                return;
            end
            for (int i = 0; i < 8; i++)
                if (inm[i]) begin
                    cnt++;
                    only = i;
                end
            if (cnt == 1) begin
                emit(only, K_PRUNE, 16'd1);
                alive = alive & ~inm;
                phase = PH_DONE;
                return;
            end
            answer_incoming(1);
            start_round();
        endfunction

        function void note_input(logic [2:0] mode, logic [2:0] src, logic [15:0] val);
            logic [7:0] b;
            logic       ok, hit;
            int         n;
            b = 8'd1 << src;
            n = links();
            ok = 0;
            batch.delete();
            if (mode == MODE_START && phase == PH_IDLE) begin
                ok = 1;
                alive = 0;
                outg = 0;
                counted = 0;
                for (int i = 0; i < n; i++) emit(i, K_RANK, own_rank);
                phase = PH_SETUP;
                if (n == 0) start_round();
            end else if (mode == MODE_RANK && phase == PH_SETUP && src < n
                         && !(alive & b)) begin
                ok = 1;
                alive = alive | b;
                if (!(val < own_rank)) outg = outg | b;
                counted = counted + 4'd1;
                if (counted >= n) start_round();
            end else if (mode == MODE_YO && phase == PH_YO
                         && (alive & ~outg & ~(seen | dup) & b) != 0) begin
                ok = 1;
                hit = 0;
                for (int i = 0; i < 8; i++) if (seen[i] && vals[i] == val) hit = 1;
                if (hit) begin
                    dup = dup | b;
                end else begin
                    seen = seen | b;
                    vals[src] = val;
                    if (val < rmin) rmin = val;
                end
                counted = counted + 4'd1;
                if ((alive & ~outg & ~(seen | dup)) == 0) close_yo();
            end else if ((mode == MODE_REPLY || mode == MODE_PRUNE) && phase == PH_REPLY
                         && (alive & outg & ~replied & b) != 0) begin
                ok = 1;
                replied = replied | b;
                if (mode == MODE_PRUNE) begin
                    alive = alive & ~b;
                end else if (!val[0]) begin
                    all_yes = 0;
                    turn = turn | b;
                end
                counted = counted + 4'd1;
                if ((alive & outg & ~replied) == 0) begin
                    answer_incoming(all_yes);
                    outg = outg & ~turn;
                    start_round();
                end
            end
            if (!ok) emit(src, K_DROP, val);
            if (batch.size() > 0) batch[batch.size() - 1].last = 1;
            foreach (batch[i]) pending = {pending, batch[i]};
        endfunction

        function void check_output(logic [2:0] d, logic [2:0] k, logic [15:0] v, logic l);
            t_send_word e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word dest=%0d kind=%0d value=%h last=%0d",
                         $time, d, k, v, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d !== e.dest) begin
                $display("%0t: dest expected %0d actual %0d", $time, e.dest, d);
                errors++;
            end
            if (k !== e.kind) begin
                $display("%0t: msg_kind expected %0d actual %0d", $time, e.kind, k);
                errors++;
            end
            if (v !== e.value) begin
                $display("%0t: value_res expected %h actual %h", $time, e.value, v);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, l);
                errors++;
            end
        endfunction

        function int pick_bit(logic [7:0] m);
            int i;
            do i = $urandom_range(0, 7); while (!m[i]);
            return i;
        endfunction

        // mostly legal protocol traffic from the neighbors, some noise
        function void pick_message(output logic [2:0] mode, output logic [2:0] src,
                                   output logic [15:0] val);
            logic [7:0] m;
            mode = 3'($urandom_range(0, 7));
            src = 3'($urandom_range(0, 7));
            val = 16'($urandom);
            if ($urandom_range(0, 99) < 20) return;
            case (phase)
                PH_IDLE: begin
                    mode = MODE_START;
                end
                PH_SETUP: begin
                    m = 0;
                    for (int i = 0; i < links(); i++) m[i] = !alive[i];
                    if (m != 0) begin
                        mode = MODE_RANK;
                        src = 3'(pick_bit(m));
                        if ($urandom_range(0, 3) == 0) val = own_rank;
                    end
                end
                PH_YO: begin
                    m = alive & ~outg & ~(seen | dup);
                    if (m != 0) begin
                        mode = MODE_YO;
                        src = 3'(pick_bit(m));
                        case ($urandom_range(0, 3))
                            0: val = 16'hFFFF;
                            1: val = 16'h0000;
                            2: val = 16'($urandom_range(0, 7));
                            default: val = 16'($urandom);
                        endcase
                    end
                end
                PH_REPLY: begin
                    m = alive & outg & ~replied;
                    if (m != 0) begin
                        mode = ($urandom_range(0, 9) == 0) ? MODE_PRUNE : MODE_REPLY;
                        src = 3'(pick_bit(m));
                        val[0] = ($urandom_range(0, 3) != 0);
                    end
                end
                default: ;
            endcase
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic [2:0]  i_mode = 0;
    logic [2:0]  i_source = 0;
    logic [15:0] i_value = 0;
    logic        i_out_stall = 0;
    logic        o_cfg_ready, o_in_stall, o_out_valid, o_last;
    logic [2:0]  o_dest, o_msg_kind;
    logic [15:0] o_value_res;

    t_election_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    localparam int WATCHDOG_LIMIT = 5000;

    yoyo_election_node_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_output(o_dest, o_msg_kind, o_value_res, o_last);
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout waiting for the node");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] mode, logic [2:0] src, logic [15:0] val);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1;
        i_mode <= mode;
        i_source <= src;
        i_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(mode, src, val);
    endtask

    task automatic send_picked();
        logic [2:0]  mode, src;
        logic [15:0] val;
        sb.pick_message(mode, src, val);
        send_word(mode, src, val);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_reg(CFG_OWN_RANK, 16'hFFFF);
        write_reg(CFG_NBR_CNT, 16'd0);
        // unexpected messages while idle
        send_word(MODE_RANK, 3'd0, 16'h0000);
        send_word(MODE_YO, 3'd7, 16'hFFFF);
        send_word(MODE_REPLY, 3'd3, 16'h0001);
        send_word(MODE_PRUNE, 3'd4, 16'h5AA5);
        send_word(3'd5, 3'd1, 16'hA55A);
        send_word(3'd6, 3'd6, 16'h0000);
        send_word(3'd7, 3'd7, 16'hFFFF);
        drain();
        write_reg(CFG_NBR_CNT, 16'd15);
        write_reg(CFG_OWN_RANK, 16'h8000);
        send_word(MODE_START, 3'd0, 16'h0000);
        send_word(MODE_START, 3'd0, 16'h0000);
        send_word(MODE_RANK, 3'd0, 16'h8000);
        send_word(MODE_RANK, 3'd1, 16'h0000);
        send_word(MODE_RANK, 3'd1, 16'h1234);
        send_word(MODE_YO, 3'd2, 16'h0001);
        drain();
        write_reg(CFG_NBR_CNT, 16'd5);
        write_reg(CFG_OWN_RANK, 16'h0000);
        write_reg(CFG_OWN_RANK, 16'h7FFF);
        send_word(MODE_RANK, 3'd7, 16'hFFFF);

        send_idle_pct = 33;
        recv_stall_pct = 65;
        repeat (83) send_picked();
        drain();
        write_reg(CFG_OWN_RANK, 16'hFFFF);

        send_idle_pct = 65;
        recv_stall_pct = 33;
        repeat (83) send_picked();
        drain();
        write_reg(CFG_OWN_RANK, 16'($urandom));

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (84) send_picked();
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (sb.pending.size() != 0)
                $display("%0t: %0d expected words never came", $time, sb.pending.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
